// ===== hdl/apu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package apu_pkg;

  // longest permutation handled
  localparam int MAX_LEN = 20;
  // field widths
  localparam int LEN_W   = 5;
  localparam int RANK_W  = 50;
  // count table addressing: {row, column}
  localparam int ROW_W     = $clog2(MAX_LEN + 1);
  localparam int ADDR_W    = ROW_W + LEN_W;
  localparam int TBL_DEPTH = (MAX_LEN + 1) << LEN_W;

  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [RANK_W-1:0] cnt_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic fill_init;
    logic fill_rd;
    logic fill_wr;
    logic pass_up;
    logic src_valid;
    logic acc_clr;
    len_t row;
    len_t col;
    logic scan_start;
    len_t pos;
    logic emit;
    logic emit_last;
    logic emit_err;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    len_t len;
    logic len_bad;
    logic rank_zero;
    logic done;
    logic chosen_zero;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== hdl/apu_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface apu_in_if;
  import apu_pkg::*;

  logic valid;
  logic ready;
  len_t length;
  cnt_t rank;

  modport source (output valid, output length, output rank, input ready);
  modport sink (input valid, input length, input rank, output ready);
endinterface

`default_nettype wire

// ===== hdl/apu_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface apu_out_if;
  import apu_pkg::*;

  logic valid;
  logic ready;
  len_t value;
  logic last;
  logic rank_error;

  modport source (output valid, output value, output last, output rank_error, input ready);
  modport sink (input valid, input value, input last, input rank_error, output ready);
endinterface

`default_nettype wire

// ===== hdl/apu_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module apu_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  apu_pkg::dp_cmd_t              cmd,
  output apu_pkg::dp_sts_t              sts,
  input  logic [apu_pkg::LEN_W-1:0]     in_length,
  input  logic [apu_pkg::RANK_W-1:0]    in_rank,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [apu_pkg::LEN_W-1:0]     out_value,
  output logic                          out_last,
  output logic                          out_rank_error
);
  import apu_pkg::*;

  function automatic cnt_t sat_add(input cnt_t a, input cnt_t b);
    logic [RANK_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[RANK_W] ? {RANK_W{1'b1}} : s[RANK_W-1:0];
  endfunction

  // count tables, up-first and down-first
  cnt_t up_mem   [TBL_DEPTH];
  cnt_t down_mem [TBL_DEPTH];
  cnt_t up_rd_r;
  cnt_t down_rd_r;

  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] scan_addr;
  logic              up_we;
  logic              down_we;
  cnt_t              wr_data;
  cnt_t              term;
  cnt_t              acc_sum;
  cnt_t              acc_r;
  len_t              fill_src_row;

  // request state
  len_t              n_r;
  cnt_t              rem_rank_r;
  logic              rank_zero_r;
  logic [MAX_LEN-1:0] used_r;
  len_t              prev_r;
  len_t              pp_r;
  len_t              chosen_r;

  // candidate pipeline
  logic              busy_r;
  logic              iss_active_r;
  len_t              iss_v_r;
  len_t              iss_no_r;
  logic              s1_valid_r;
  len_t              s1_v_r;
  logic              s2_valid_r;
  len_t              s2_v_r;
  cnt_t              s2_cnt_r;
  logic              done_r;

  len_t              rem;
  len_t              fv;
  logic              found;
  len_t              no_next;
  logic              issue;
  cnt_t              cnt1;
  logic              choose;
  logic              drain;

  // output register
  logic              out_valid_r;
  len_t              out_value_r;
  logic              out_last_r;
  logic              out_err_r;

  assign rem     = n_r - cmd.pos + LEN_W'(1);
  assign no_next = iss_no_r + LEN_W'(1);

  // lowest unused value at or above the scan point
  always_comb begin
    fv    = '0;
    found = 1'b0;
    for (int j = MAX_LEN - 1; j >= 0; j--) begin
      if (!used_r[j] && (LEN_W'(j + 1) >= iss_v_r) && (LEN_W'(j + 1) <= n_r)) begin
        fv    = LEN_W'(j + 1);
        found = 1'b1;
      end
    end
  end

  assign issue     = busy_r && iss_active_r && found && (no_next <= rem);
  assign scan_addr = {rem[ROW_W-1:0], no_next};

  assign fill_src_row = cmd.row - LEN_W'(1);
  assign rd_addr = cmd.fill_rd ? {fill_src_row[ROW_W-1:0], cmd.col} : scan_addr;
  assign wr_addr = cmd.fill_init ? {ROW_W'(1), LEN_W'(1)} : {cmd.row[ROW_W-1:0], cmd.col};

  assign term    = cmd.src_valid ? (cmd.pass_up ? down_rd_r : up_rd_r) : '0;
  assign acc_sum = sat_add(acc_r, term);
  assign wr_data = cmd.fill_init ? RANK_W'(1) : (cmd.pass_up ? acc_sum : acc_r);
  assign up_we   = cmd.fill_init || (cmd.fill_wr && cmd.pass_up);
  assign down_we = cmd.fill_init || (cmd.fill_wr && !cmd.pass_up);

  // count of the candidate whose table entry just arrived
  always_comb begin
    if (cmd.pos == LEN_W'(1)) begin
      cnt1 = (n_r == LEN_W'(1)) ? RANK_W'(1) : sat_add(up_rd_r, down_rd_r);
    end else if (s1_v_r > prev_r && (cmd.pos <= LEN_W'(2) || pp_r > prev_r)) begin
      cnt1 = down_rd_r;
    end else if (s1_v_r < prev_r && (cmd.pos <= LEN_W'(2) || pp_r < prev_r)) begin
      cnt1 = up_rd_r;
    end else begin
      cnt1 = '0;
    end
  end

  assign choose = s2_valid_r && (s2_cnt_r >= rem_rank_r);
  assign drain  = busy_r && !iss_active_r && !s1_valid_r && !s2_valid_r;

  always_ff @(posedge clk) begin
    if (up_we) begin
      up_mem[wr_addr] <= wr_data;
    end
    if (down_we) begin
      down_mem[wr_addr] <= wr_data;
    end
    up_rd_r   <= up_mem[rd_addr];
    down_rd_r <= down_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      iss_active_r <= 1'b0;
      s1_valid_r   <= 1'b0;
      s2_valid_r   <= 1'b0;
      done_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (cmd.scan_start) begin
        busy_r       <= 1'b1;
        iss_active_r <= 1'b1;
        s1_valid_r   <= 1'b0;
        s2_valid_r   <= 1'b0;
      end else if (busy_r) begin
        s1_valid_r <= issue && !choose;
        s2_valid_r <= s1_valid_r && !choose;
        if (choose || !issue) begin
          iss_active_r <= 1'b0;
        end
        if (choose || drain) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_r         <= in_length;
      rem_rank_r  <= in_rank;
      rank_zero_r <= (in_rank == '0);
      used_r      <= '0;
      prev_r      <= '0;
      pp_r        <= '0;
    end
    if (cmd.fill_init) begin
      acc_r <= '0;
    end else if (cmd.fill_wr) begin
      acc_r <= cmd.acc_clr ? '0 : acc_sum;
    end
    if (cmd.scan_start) begin
      iss_v_r  <= LEN_W'(1);
      iss_no_r <= '0;
    end else if (issue) begin
      iss_v_r  <= fv + LEN_W'(1);
      iss_no_r <= no_next;
    end
    s1_v_r   <= fv;
    s2_v_r   <= s1_v_r;
    s2_cnt_r <= cnt1;
    if (choose) begin
      chosen_r <= s2_v_r;
      pp_r     <= prev_r;
      prev_r   <= s2_v_r;
      for (int j = 0; j < MAX_LEN; j++) begin
        if (s2_v_r == LEN_W'(j + 1)) begin
          used_r[j] <= 1'b1;
        end
      end
    end else if (s2_valid_r) begin
      rem_rank_r <= rem_rank_r - s2_cnt_r;
    end else if (drain) begin
      chosen_r <= '0;
      pp_r     <= prev_r;
      prev_r   <= '0;
    end
    if (cmd.emit) begin
      out_value_r <= cmd.emit_err ? '0 : chosen_r;
      out_last_r  <= cmd.emit_last;
      out_err_r   <= cmd.emit_err;
    end
  end

  assign sts.len         = n_r;
  assign sts.len_bad     = (n_r == '0) || (n_r > LEN_W'(MAX_LEN));
  assign sts.rank_zero   = rank_zero_r;
  assign sts.done        = done_r;
  assign sts.chosen_zero = (chosen_r == '0);
  assign sts.out_free    = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign out_value      = out_value_r;
  assign out_last       = out_last_r;
  assign out_rank_error = out_err_r;

endmodule

`default_nettype wire

// ===== hdl/apu_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module apu_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  apu_pkg::dp_sts_t  sts,
  output apu_pkg::dp_cmd_t  cmd
);
  import apu_pkg::*;

  typedef enum logic [2:0] {
    S_FILL_INIT,
    S_FILL_RD,
    S_FILL_WR,
    S_IDLE,
    S_CHECK,
    S_SCAN_GO,
    S_SCAN_WAIT,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  len_t   row_r, row_nxt;
  len_t   col_r, col_nxt;
  logic   pass_up_r, pass_up_nxt;
  len_t   pos_r, pos_nxt;
  logic   err_r, err_nxt;

  always_comb begin
    state_nxt   = state_r;
    row_nxt     = row_r;
    col_nxt     = col_r;
    pass_up_nxt = pass_up_r;
    pos_nxt     = pos_r;
    err_nxt     = err_r;
    in_ready    = 1'b0;
    cmd           = '0;
    cmd.row       = row_r;
    cmd.col       = col_r;
    cmd.pass_up   = pass_up_r;
    cmd.src_valid = (col_r < row_r);
    cmd.pos       = pos_r;
    cmd.emit_last = (pos_r == sts.len);
    cmd.emit_err  = err_r;
    case (state_r)
      S_FILL_INIT: begin
        cmd.fill_init = 1'b1;
        row_nxt       = LEN_W'(2);
        col_nxt       = LEN_W'(1);
        pass_up_nxt   = 1'b0;
        state_nxt     = S_FILL_RD;
      end
      S_FILL_RD: begin
        cmd.fill_rd = 1'b1;
        state_nxt   = S_FILL_WR;
      end
      S_FILL_WR: begin
        cmd.fill_wr = 1'b1;
        state_nxt   = S_FILL_RD;
        if (!pass_up_r) begin
          if (col_r == row_r) begin
            cmd.acc_clr = 1'b1;
            pass_up_nxt = 1'b1;
          end else begin
            col_nxt = col_r + LEN_W'(1);
          end
        end else if (col_r == LEN_W'(1)) begin
          cmd.acc_clr = 1'b1;
          pass_up_nxt = 1'b0;
          row_nxt     = row_r + LEN_W'(1);
          if (row_r == LEN_W'(MAX_LEN)) begin
            state_nxt = S_IDLE;
          end
        end else begin
          col_nxt = col_r - LEN_W'(1);
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.len_bad) begin
          state_nxt = S_IDLE;
        end else begin
          pos_nxt   = LEN_W'(1);
          err_nxt   = 1'b0;
          state_nxt = S_SCAN_GO;
        end
      end
      S_SCAN_GO: begin
        cmd.scan_start = 1'b1;
        state_nxt      = S_SCAN_WAIT;
      end
      S_SCAN_WAIT: begin
        if (sts.done) begin
          if (pos_r == LEN_W'(1) && (sts.rank_zero || sts.chosen_zero)) begin
            err_nxt = 1'b1;
          end
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (pos_r == sts.len) begin
            state_nxt = S_IDLE;
          end else begin
            pos_nxt   = pos_r + LEN_W'(1);
            state_nxt = err_r ? S_EMIT : S_SCAN_GO;
          end
        end
      end
      default: begin
        state_nxt = S_FILL_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_FILL_INIT;
      row_r     <= '0;
      col_r     <= '0;
      pass_up_r <= 1'b0;
      pos_r     <= '0;
      err_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      row_r     <= row_nxt;
      col_r     <= col_nxt;
      pass_up_r <= pass_up_nxt;
      pos_r     <= pos_nxt;
      err_r     <= err_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/alternating_permutation_unrank.sv =====
`timescale 1ns / 1ps
`default_nettype none

// alternating permutation unranking: a word on in_chan carries a length n (1..MAX_LEN) and a
// 1-based rank; the block answers with n words on out_chan, the rank-th zigzag permutation of
// 1..n in lexicographic order, one value per word, last set on the final one. a rank of zero
// or above the number of zigzag permutations gives n words with value 0 and rank_error set;
// a length of zero or above MAX_LEN gives no words. after reset the block builds its up/down
// count tables and holds in_chan.ready low until they are built. one word is worked on at a
// time: for each position the candidate pipeline reads one table entry a cycle, one per
// candidate value tried, and a result may wait for out_chan.ready.
// the output register lets the next position be worked while a result waits for out_chan.ready

module alternating_permutation_unrank (
  input  logic       clk,
  input  logic       rst_n,
  apu_in_if.sink     in_chan,
  apu_out_if.source  out_chan
);
  import apu_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    ctrl_in_ready;

  // sequencing: table build, position loop, result hand-off
  apu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (ctrl_in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // count tables, candidate pipeline, rank bookkeeping and output register
  apu_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_length      (in_chan.length),
    .in_rank        (in_chan.rank),
    .out_ready      (out_chan.ready),
    .out_valid      (out_chan.valid),
    .out_value      (out_chan.value),
    .out_last       (out_chan.last),
    .out_rank_error (out_chan.rank_error)
  );

  assign in_chan.ready = ctrl_in_ready;

endmodule

`default_nettype wire

// ===== verif/apu_checker.sv =====
`timescale 1ns / 1ps

module apu_checker (
  input  logic clk,
  input  logic rst_n,
  apu_in_if    in_chan,
  apu_out_if   out_chan,
  output int   fail_count,
  output int   outstanding
);
  import apu_pkg::*;

  localparam cnt_t CNT_LIM    = '1;
  localparam int   UP_FIRST   = 0;
  localparam int   DOWN_FIRST = 1;

  typedef struct packed {
    len_t value;
    logic last;
    logic rank_error;
  } zz_word_t;

  // ways[i][k][dir]: zigzag arrangements of i items starting at the k-th smallest
  cnt_t ways [0:MAX_LEN][0:MAX_LEN][0:1];
  // number of zigzag permutations per length, zero where no words come back
  cnt_t total_of [0:(1 << LEN_W) - 1];

  logic [MAX_LEN-1:0] placed;
  len_t               prev_val;
  len_t               prev2_val;
  cnt_t               rank_left;
  zz_word_t           perm_q[$];
  int                 errs;

  function automatic cnt_t sat_sum(cnt_t a, cnt_t b);
    logic [RANK_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, CNT_LIM}) ? CNT_LIM : s[RANK_W-1:0];
  endfunction

  initial begin : fill_ways
    cnt_t up_sum;
    cnt_t down_sum;
    for (int i = 0; i <= MAX_LEN; i++)
      for (int k = 0; k <= MAX_LEN; k++) begin
        ways[i][k][UP_FIRST]   = '0;
        ways[i][k][DOWN_FIRST] = '0;
      end
    ways[1][1][UP_FIRST]   = 1;
    ways[1][1][DOWN_FIRST] = 1;
    for (int i = 2; i <= MAX_LEN; i++)
      for (int k = 1; k <= i; k++) begin
        up_sum   = '0;
        down_sum = '0;
        for (int m = k; m < i; m++) up_sum = sat_sum(up_sum, ways[i-1][m][DOWN_FIRST]);
        for (int m = 1; m < k; m++) down_sum = sat_sum(down_sum, ways[i-1][m][UP_FIRST]);
        ways[i][k][UP_FIRST]   = up_sum;
        ways[i][k][DOWN_FIRST] = down_sum;
      end
    foreach (total_of[n]) total_of[n] = '0;
    // a single element is one permutation, not one per direction
    total_of[1] = 1;
    for (int n = 2; n <= MAX_LEN; n++)
      for (int k = 1; k <= n; k++)
        total_of[n] = sat_sum(total_of[n], sat_sum(ways[n][k][UP_FIRST], ways[n][k][DOWN_FIRST]));
  end

  task automatic unrank_word(len_t n, cnt_t rank);
    int       rem;
    int       seen;
    len_t     pick;
    cnt_t     ways_here;
    zz_word_t w;
    if (n < 1 || n > MAX_LEN) return;
    placed    = '0;
    prev_val  = '0;
    prev2_val = '0;
    rank_left = rank;
    if (rank == '0 || rank > total_of[n]) begin
      for (int pos = 1; pos <= n; pos++) begin
        w.value      = '0;
        w.last       = (pos == n);
        w.rank_error = 1'b1;
        perm_q.push_back(w);
      end
      return;
    end
    for (int pos = 1; pos <= n; pos++) begin
      rem  = n - pos + 1;
      seen = 0;
      pick = '0;
      for (int v = 1; v <= n; v++) begin
        if (placed[v-1]) continue;
        seen++;
        if (seen > rem) break;
        ways_here = '0;
        if (pos == 1)
          ways_here = (n == 1) ? cnt_t'(1) :
                      sat_sum(ways[n][seen][UP_FIRST], ways[n][seen][DOWN_FIRST]);
        else if (v > prev_val && (pos <= 2 || prev2_val > prev_val))
          ways_here = ways[rem][seen][DOWN_FIRST];
        else if (v < prev_val && (pos <= 2 || prev2_val < prev_val))
          ways_here = ways[rem][seen][UP_FIRST];
        if (ways_here >= rank_left) begin
          pick = len_t'(v);
          break;
        end
        rank_left -= ways_here;
      end
      if (pick != '0) placed[pick-1] = 1'b1;
      prev2_val    = prev_val;
      prev_val     = pick;
      w.value      = pick;
      w.last       = (pos == n);
      w.rank_error = 1'b0;
      perm_q.push_back(w);
    end
  endtask

  always @(posedge clk) begin : watch
    zz_word_t want;
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready) unrank_word(in_chan.length, in_chan.rank);
      if (out_chan.valid && out_chan.ready) begin
        if (perm_q.size() == 0) begin
          $error("unexpected word: value %0d last %0b rank_error %0b",
                 out_chan.value, out_chan.last, out_chan.rank_error);
          errs++;
        end else begin
          want = perm_q.pop_front();
          if (out_chan.value !== want.value) begin
            $error("value: expected %0d, actual %0d", want.value, out_chan.value);
            errs++;
          end
          if (out_chan.last !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, out_chan.last);
            errs++;
          end
          if (out_chan.rank_error !== want.rank_error) begin
            $error("rank_error: expected %0b, actual %0b", want.rank_error, out_chan.rank_error);
            errs++;
          end
        end
      end
      outstanding <= perm_q.size();
      fail_count  <= errs;
    end
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import apu_pkg::*;

  // well above the slowest run: table fill and ~130 words, stalled results included
  localparam int   CYCLE_LIMIT  = 400000;
  // quiet cycles after the last result, enough for a stray extra word to show
  localparam int   TAIL_CYCLES  = 60;
  localparam int   RANDOM_WORDS = 105;
  localparam cnt_t RANK_ONES    = '1;

  logic clk;
  logic rst_n;
  logic no_idle;
  int   fail_count;
  int   outstanding;
  int   cycle_count;

  apu_in_if  in_chan();
  apu_out_if out_chan();

  alternating_permutation_unrank u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // predicts every permutation and compares result words as they leave
  apu_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // result side: back-pressure about 28 percent of the time, none during the steady stretch
  always @(posedge clk) begin
    out_chan.ready <= no_idle || ($urandom_range(99) >= 28);
  end

  // watchdog, counts from time zero so the table fill is included
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // one request word; random gaps ahead of it, valid held across back-to-back words
  task automatic send_word(len_t n, cnt_t rank);
    while (!no_idle && $urandom_range(99) < 28) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid  <= 1'b1;
    in_chan.length <= n;
    in_chan.rank   <= rank;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  // stop sending until every predicted word has come back
  task automatic wait_all_out();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // rank inside 1..total, with the two ends now and then
  function automatic cnt_t rank_inside(len_t n);
    longint unsigned total;
    longint unsigned r64;
    total = u_check.total_of[n];
    r64   = {$urandom, $urandom};
    case ($urandom_range(9))
      0:       return cnt_t'(1);
      1:       return cnt_t'(total);
      default: return cnt_t'(r64 % total + 1);
    endcase
  endfunction

  // zero or anything above the total
  function automatic cnt_t rank_outside(len_t n);
    longint unsigned total;
    longint unsigned r64;
    total = u_check.total_of[n];
    r64   = {$urandom, $urandom};
    case ($urandom_range(3))
      0:       return '0;
      1:       return cnt_t'(total + 1);
      2:       return RANK_ONES;
      default: return cnt_t'(total + 1 + r64 % (longint'(RANK_ONES) - total));
    endcase
  endfunction

  initial begin : stimulus
    int   sent;
    len_t n;
    cnt_t rank;
    in_chan.valid  <= 1'b0;
    in_chan.length <= '0;
    in_chan.rank   <= '0;
    no_idle        <= 1'b0;
    rst_n          <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed words; the block holds ready low while it builds its tables
    // single element: [1] is the only permutation
    send_word(5'd1, 50'd1);
    send_word(5'd1, 50'd2);
    // rank zero is out of range
    send_word(5'd1, '0);
    send_word(5'd2, 50'd1);
    send_word(5'd2, 50'd2);
    send_word(5'd2, 50'd3);
    for (int r = 1; r <= 4; r++) send_word(5'd3, cnt_t'(r));
    send_word(5'd4, 50'd1);
    send_word(5'd4, u_check.total_of[4]);
    send_word(5'd5, u_check.total_of[5]);
    send_word(5'd5, u_check.total_of[5] + 1);
    // longest length: first, last, just past the end, all rank bits set
    send_word(5'd20, 50'd1);
    send_word(5'd20, u_check.total_of[20]);
    send_word(5'd20, u_check.total_of[20] + 1);
    send_word(5'd20, RANK_ONES);
    // lengths the block drops without a word back
    send_word(5'd0, 50'd7);
    send_word(5'd21, 50'd1);
    send_word(5'd31, RANK_ONES);
    send_word(5'd6, 50'd3);
    send_word(5'd9, 50'd100);
    wait_all_out();

    // random words, mostly valid ranks on short lengths
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      no_idle <= (sent >= 40 && sent < 80);
      if (sent == 100) wait_all_out();
      if ($urandom_range(99) < 4) begin
        n = ($urandom_range(1) == 0) ? len_t'(0) : len_t'($urandom_range(MAX_LEN + 1, 31));
        send_word(n, cnt_t'({$urandom, $urandom}));
      end else begin
        n    = ($urandom_range(99) < 60) ? len_t'($urandom_range(1, 8)) :
                                           len_t'($urandom_range(9, MAX_LEN));
        rank = ($urandom_range(99) < 88) ? rank_inside(n) : rank_outside(n);
        send_word(n, rank);
        sent++;
      end
    end
    no_idle <= 1'b0;
    wait_all_out();
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);

    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
